// ----- rtl/core/stdf_pkg.sv -----
// shared constants, codes and types for the square table duplicate finder
// no dependencies; imported by stdf_cell and the top level
`default_nettype none

package stdf_pkg;

   localparam int SQUARES = 64;
   localparam int BANKS   = 2;

   localparam int SQ_W    = $clog2(SQUARES);
   localparam int CNT_W   = $clog2(SQUARES + 1);
   localparam int OP_W    = 3;
   localparam int BANK_W  = 1;
   localparam int SQIN_W  = 7;
   localparam int COLOR_W = 2;
   localparam int KIND_W  = 3;
   localparam int ID_W    = 64;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 7;

   localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
   localparam logic [OP_W-1:0] OP_PLACE = 3'd1;
   localparam logic [OP_W-1:0] OP_COUNT = 3'd2;
   localparam logic [OP_W-1:0] OP_DUP   = 3'd3;
   localparam logic [OP_W-1:0] OP_CMP   = 3'd4;

   typedef struct packed {
      logic               occ;
      logic [COLOR_W-1:0] color;
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    id;
   } reading_type;

   typedef struct packed {
      logic              shift;
      logic              clear;
      logic [BANK_W-1:0] bank;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/core/stdf_cell.sv -----
// one square of the ring: both banks' readings, rotate to neighbor, id match
// depends on stdf_pkg
`default_nettype none

module stdf_cell
   import stdf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cell_ctl_type             ctl,
   input  wire logic                     wr_en,
   input  wire reading_type              wr_data,
   input  wire reading_type [BANKS-1:0]  nbr_in,
   input  wire reading_type              probe,
   output      reading_type [BANKS-1:0]  cur,
   output      logic                     hit
);

   logic [BANKS-1:0]   occ_ff;
   logic [BANKS-1:0]   occ_in;
   logic [COLOR_W-1:0] color_ff [BANKS];
   logic [KIND_W-1:0]  kind_ff  [BANKS];
   logic [ID_W-1:0]    id_ff    [BANKS];

   always_comb begin
      for (int b = 0; b < BANKS; b++) begin
         if (ctl.shift) begin
            occ_in[b] = nbr_in[b].occ;
         end else if (wr_en && ctl.bank == BANK_W'(b)) begin
            occ_in[b] = 1'b1;
         end else if (ctl.clear && ctl.bank == BANK_W'(b)) begin
            occ_in[b] = 1'b0;
         end else begin
            occ_in[b] = occ_ff[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // payload is only read where occupied
   always_ff @(posedge clock) begin
      for (int b = 0; b < BANKS; b++) begin
         if (ctl.shift) begin
            color_ff[b] <= nbr_in[b].color;
            kind_ff[b]  <= nbr_in[b].kind;
            id_ff[b]    <= nbr_in[b].id;
         end else if (wr_en && ctl.bank == BANK_W'(b)) begin
            color_ff[b] <= wr_data.color;
            kind_ff[b]  <= wr_data.kind;
            id_ff[b]    <= wr_data.id;
         end
      end
   end

   always_comb begin
      for (int b = 0; b < BANKS; b++) begin
         cur[b].occ   = occ_ff[b];
         cur[b].color = color_ff[b];
         cur[b].kind  = kind_ff[b];
         cur[b].id    = id_ff[b];
      end
   end

   assign hit = cur[ctl.bank].occ && probe.occ && (cur[ctl.bank].id == probe.id);

endmodule

`default_nettype wire

// ----- rtl/core/square_table_duplicate_finder_unit.sv -----
// square table duplicate finder: two banks of per-square readings with
// clear, place, count, duplicate id search and bank compare.
// Channels: req_* carries one operation per transfer, rsp_* returns exactly
// one result per operation, both valid/ready.
// Storage is a ring of SQUARES cells. Clear and place act on the transfer
// edge; the done state then loads their all-zero result for the output.
// Count, duplicate search and compare rotate the ring one square per cycle
// for a full turn, so cell 0 sees every square in order while every cell
// compares its id against cell 0. The flush state drains the match stage,
// then the done state loads the result into the output register.
// Queries are paced by the ring walk; clear and place skip it and go
// straight to the done state.
// One operation is in flight at a time; a finished result waits in the
// output register while the next request is taken, and the block holds the
// following result until the receiver takes the earlier one.
// Reset empties both banks and drops any pending result.
// depends on stdf_pkg and stdf_cell
`default_nettype none

module square_table_duplicate_finder_unit
   import stdf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [OP_W-1:0]    req_operation,
   input  wire logic [BANK_W-1:0]  req_bank,
   input  wire logic [SQIN_W-1:0]  req_square,
   input  wire logic [COLOR_W-1:0] req_color,
   input  wire logic [KIND_W-1:0]  req_piece_kind,
   input  wire logic [ID_W-1:0]    req_tag_id,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic               rsp_flag,
   output      logic [POS_W-1:0]   rsp_first_square,
   output      logic [POS_W-1:0]   rsp_second_square,
   output      logic [COUNT_W-1:0] rsp_occupied_count
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;
   localparam int MW = SQ_W + 1;

   function automatic logic [SQ_W-1:0] lowest_set(input logic [SQUARES-1:0] v);
      logic [SQ_W-1:0] idx;
      idx = '0;
      for (int i = SQUARES - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = SQ_W'(i);
         end
      end
      return idx;
   endfunction

   logic [1:0]         state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [BANK_W-1:0]  bank_ff, bank_in;
   logic [SQ_W-1:0]    k_ff, k_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [SQ_W-1:0]    s1_k_ff;
   logic [SQUARES-1:0] s1_hit_ff;
   logic               s1_occ_ff;
   logic               s1_diff_ff;
   logic               found_ff, found_in;
   logic [SQ_W-1:0]    first_ff, first_in;
   logic [SQ_W-1:0]    second_ff, second_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               neq_ff, neq_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_flag_ff;
   logic [POS_W-1:0]   rsp_first_ff;
   logic [POS_W-1:0]   rsp_second_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic               accept;
   logic               is_scan_op;
   logic               slot_free;
   logic               load_rsp;
   cell_ctl_type       ctl;
   reading_type        wr_data;
   reading_type        probe;
   reading_type [BANKS-1:0] cur [SQUARES];
   logic [SQUARES-1:0] hit;
   logic [SQUARES-1:0] hit_masked;
   logic [SQUARES-1:0] wr_en;
   logic               cell0_diff;
   logic               res_flag;
   logic [POS_W-1:0]   res_first;
   logic [POS_W-1:0]   res_second;
   logic [COUNT_W-1:0] res_count;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign is_scan_op = (req_operation == OP_COUNT) || (req_operation == OP_DUP) ||
                       (req_operation == OP_CMP);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign load_rsp   = (state_ff == ST_DONE) && slot_free;

   // cell ring
   assign ctl.shift     = (state_ff == ST_SCAN);
   assign ctl.clear     = accept && (req_operation == OP_CLEAR);
   assign ctl.bank      = (state_ff == ST_IDLE) ? req_bank : bank_ff;
   assign wr_data.occ   = 1'b1;
   assign wr_data.color = req_color;
   assign wr_data.kind  = req_piece_kind;
   assign wr_data.id    = req_tag_id;
   assign probe         = cur[0][ctl.bank];

   for (genvar c = 0; c < SQUARES; c++) begin : g_cell
      localparam int NX = (c + 1) % SQUARES;

      assign wr_en[c] = accept && (req_operation == OP_PLACE) &&
                        ((SQIN_W + 1)'(req_square) == (SQIN_W + 1)'(c));

      stdf_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .wr_en   (wr_en[c]),
         .wr_data (wr_data),
         .nbr_in  (cur[NX]),
         .probe   (probe),
         .cur     (cur[c]),
         .hit     (hit[c])
      );

      // only squares above the one in cell 0, before the wrap
      if (c == 0) begin : g_self
         assign hit_masked[c] = 1'b0;
      end else begin : g_other
         assign hit_masked[c] = hit[c] &&
                                ((MW'(c) + {1'b0, k_ff}) < MW'(SQUARES));
      end
   end

   assign cell0_diff = (cur[0][0].occ != cur[0][1].occ) ||
                       (cur[0][0].occ && ((cur[0][0].color != cur[0][1].color) ||
                                          (cur[0][0].kind != cur[0][1].kind) ||
                                          (cur[0][0].id != cur[0][1].id)));

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      bank_in     = bank_ff;
      k_in        = k_ff;
      found_in    = found_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      cnt_in      = cnt_ff;
      neq_in      = neq_ff;
      s1_valid_in = (state_ff == ST_SCAN);

      if (s1_valid_ff) begin
         cnt_in = cnt_ff + CNT_W'(s1_occ_ff);
         neq_in = neq_ff | s1_diff_ff;
         if (!found_ff && (|s1_hit_ff)) begin
            found_in  = 1'b1;
            first_in  = s1_k_ff;
            second_in = s1_k_ff + lowest_set(s1_hit_ff);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               bank_in  = req_bank;
               k_in     = '0;
               found_in = 1'b0;
               cnt_in   = '0;
               neq_in   = 1'b0;
               state_in = is_scan_op ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            k_in = k_ff + SQ_W'(1);
            if (k_ff == SQ_W'(SQUARES - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_flag   = ((op_ff == OP_DUP) && found_ff) || ((op_ff == OP_CMP) && !neq_ff);
   assign res_first  = ((op_ff == OP_DUP) && found_ff) ? POS_W'(first_ff) : '0;
   assign res_second = ((op_ff == OP_DUP) && found_ff) ? POS_W'(second_ff) : '0;
   assign res_count  = (op_ff == OP_COUNT) ? COUNT_W'(cnt_ff) : '0;

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         cnt_ff       <= '0;
         neq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         found_ff     <= found_in;
         cnt_ff       <= cnt_in;
         neq_ff       <= neq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      bank_ff    <= bank_in;
      k_ff       <= k_in;
      first_ff   <= first_in;
      second_ff  <= second_in;
      s1_k_ff    <= k_ff;
      s1_hit_ff  <= hit_masked;
      s1_occ_ff  <= probe.occ;
      s1_diff_ff <= cell0_diff;
      if (load_rsp) begin
         rsp_flag_ff   <= res_flag;
         rsp_first_ff  <= res_first;
         rsp_second_ff <= res_second;
         rsp_count_ff  <= res_count;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_flag           = rsp_flag_ff;
   assign rsp_first_square   = rsp_first_ff;
   assign rsp_second_square  = rsp_second_ff;
   assign rsp_occupied_count = rsp_count_ff;

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && k_ff == SQ_W'(SQUARES - 1)) |=> (state_ff == ST_FLUSH))
      else $error("ring walk did not end after a full turn");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (second_ff > first_ff))
      else $error("duplicate pair out of order");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SQUARES))
      else $error("occupied count beyond board size");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result offered outside the done state");

endmodule

`default_nettype wire

// ----- tb/square_table_duplicate_finder_unit_test.sv -----
// testbench for square_table_duplicate_finder_unit: directed and random operations on two
// banks, each result checked against a behavioral model of the square table
// depends on stdf_pkg and the square_table_duplicate_finder_unit rtl
`timescale 1ns / 1ps

module square_table_duplicate_finder_unit_test;
   import stdf_pkg::*;

   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = SQUARES + 8;

   typedef struct packed {
      logic               flag;
      logic [POS_W-1:0]   first;
      logic [POS_W-1:0]   second;
      logic [COUNT_W-1:0] count;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [OP_W-1:0]    req_operation;
   logic [BANK_W-1:0]  req_bank;
   logic [SQIN_W-1:0]  req_square;
   logic [COLOR_W-1:0] req_color;
   logic [KIND_W-1:0]  req_piece_kind;
   logic [ID_W-1:0]    req_tag_id;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_flag;
   logic [POS_W-1:0]   rsp_first_square;
   logic [POS_W-1:0]   rsp_second_square;
   logic [COUNT_W-1:0] rsp_occupied_count;

   // board model
   logic               board_occ   [BANKS][SQUARES];
   logic [COLOR_W-1:0] board_color [BANKS][SQUARES];
   logic [KIND_W-1:0]  board_kind  [BANKS][SQUARES];
   logic [ID_W-1:0]    board_id    [BANKS][SQUARES];

   answer_type awaited_answers[$];
   answer_type oldest_answer;
   logic [ID_W-1:0] id_pool [16];

   int mismatches = 0;
   int answers_checked = 0;
   int requests_sent = 0;
   int queries_sent = 0;
   int dup_hits = 0;
   int equal_hits = 0;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   int hold_requests = 0;
   int holds_served = 0;
   int rx_hold_left = 0;
   int rx_gap_left = 0;

   square_table_duplicate_finder_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_bank           (req_bank),
      .req_square         (req_square),
      .req_color          (req_color),
      .req_piece_kind     (req_piece_kind),
      .req_tag_id         (req_tag_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_flag           (rsp_flag),
      .rsp_first_square   (rsp_first_square),
      .rsp_second_square  (rsp_second_square),
      .rsp_occupied_count (rsp_occupied_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("timeout with %0d results outstanding", awaited_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ID_W-1:0] rand_id();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SQIN_W-1:0] rand_square();
      if ($urandom_range(0, 99) < 85) return SQIN_W'($urandom_range(0, SQUARES - 1));
      return SQIN_W'($urandom_range(SQUARES, (1 << SQIN_W) - 1));
   endfunction

   function automatic void clear_board_model();
      for (int b = 0; b < BANKS; b++) begin
         for (int s = 0; s < SQUARES; s++) begin
            board_occ[b][s] = 1'b0;
            board_color[b][s] = '0;
            board_kind[b][s] = '0;
            board_id[b][s] = '0;
         end
      end
   endfunction

   function automatic answer_type predict_board_op(
      input logic [OP_W-1:0]    op,
      input logic [BANK_W-1:0]  bank,
      input logic [SQIN_W-1:0]  sq,
      input logic [COLOR_W-1:0] color,
      input logic [KIND_W-1:0]  kind,
      input logic [ID_W-1:0]    id
   );
      answer_type ans;
      bit hit;
      ans = '0;
      hit = 1'b0;
      case (op)
         OP_CLEAR: begin
            for (int s = 0; s < SQUARES; s++) begin
               board_occ[bank][s] = 1'b0;
               board_color[bank][s] = '0;
               board_kind[bank][s] = '0;
               board_id[bank][s] = '0;
            end
         end
         OP_PLACE: begin
            if (sq < SQUARES) begin
               board_occ[bank][sq[SQ_W-1:0]] = 1'b1;
               board_color[bank][sq[SQ_W-1:0]] = color;
               board_kind[bank][sq[SQ_W-1:0]] = kind;
               board_id[bank][sq[SQ_W-1:0]] = id;
            end
         end
         OP_COUNT: begin
            for (int s = 0; s < SQUARES; s++)
               if (board_occ[bank][s]) ans.count = ans.count + COUNT_W'(1);
         end
         OP_DUP: begin
            for (int i = 0; i < SQUARES && !hit; i++) begin
               if (board_occ[bank][i]) begin
                  for (int j = i + 1; j < SQUARES && !hit; j++) begin
                     if (board_occ[bank][j] && board_id[bank][i] == board_id[bank][j]) begin
                        hit = 1'b1;
                        ans.first = POS_W'(i);
                        ans.second = POS_W'(j);
                     end
                  end
               end
            end
            ans.flag = hit;
         end
         OP_CMP: begin
            ans.flag = 1'b1;
            for (int s = 0; s < SQUARES; s++) begin
               if (board_occ[0][s] != board_occ[1][s]) begin
                  ans.flag = 1'b0;
               end else if (board_occ[0][s] &&
                            (board_color[0][s] != board_color[1][s] ||
                             board_kind[0][s] != board_kind[1][s] ||
                             board_id[0][s] != board_id[1][s])) begin
                  ans.flag = 1'b0;
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   // entered and left at a rising edge
   task automatic send_request(
      input logic [OP_W-1:0]    op,
      input logic [BANK_W-1:0]  bank,
      input logic [SQIN_W-1:0]  sq,
      input logic [COLOR_W-1:0] color,
      input logic [KIND_W-1:0]  kind,
      input logic [ID_W-1:0]    id
   );
      int gap;
      answer_type ans;
      gap = tx_steady ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_bank <= bank;
      req_square <= sq;
      req_color <= color;
      req_piece_kind <= kind;
      req_tag_id <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ans = predict_board_op(op, bank, sq, color, kind, id);
      awaited_answers.push_back(ans);
      requests_sent++;
      if (op == OP_COUNT || op == OP_DUP || op == OP_CMP) queries_sent++;
      if (op == OP_DUP && ans.flag) dup_hits++;
      if (op == OP_CMP && ans.flag) equal_hits++;
   endtask

   task automatic send_query(input logic [OP_W-1:0] op, input logic [BANK_W-1:0] bank);
      send_request(op, bank, rand_square(), COLOR_W'($urandom), KIND_W'($urandom), rand_id());
   endtask

   task automatic wait_all_answered();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_answers.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_answers.size() == 0) begin
            report_mismatch("result transfer with nothing pending", 32'(rsp_flag), 32'd0);
         end else begin
            oldest_answer = awaited_answers.pop_front();
            if (rsp_flag !== oldest_answer.flag)
               report_mismatch("flag", 32'(rsp_flag), 32'(oldest_answer.flag));
            if (rsp_first_square !== oldest_answer.first)
               report_mismatch("first_square", 32'(rsp_first_square),
                               32'(oldest_answer.first));
            if (rsp_second_square !== oldest_answer.second)
               report_mismatch("second_square", 32'(rsp_second_square),
                               32'(oldest_answer.second));
            if (rsp_occupied_count !== oldest_answer.count)
               report_mismatch("occupied_count", 32'(rsp_occupied_count),
                               32'(oldest_answer.count));
            answers_checked++;
         end
      end
   end

   // receiver readiness with random stalls and requested long hold-offs
   always @(posedge clock) begin
      if (holds_served < hold_requests) begin
         holds_served++;
         rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rx_gap_left > 0) begin
         rx_gap_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!rx_steady) rx_gap_left = gap_len();
      end
   end

   task automatic test_reset_state();
      send_query(OP_COUNT, 1'b0);
      send_query(OP_COUNT, 1'b1);
      send_query(OP_DUP, 1'b0);
      send_query(OP_DUP, 1'b1);
      send_query(OP_CMP, BANK_W'($urandom));
   endtask

   task automatic test_board_edges();
      send_request(OP_PLACE, 1'b0, '0, '1, '1, '1);
      send_request(OP_PLACE, 1'b0, SQIN_W'(SQUARES - 1), '0, '0, '1);
      send_query(OP_DUP, 1'b0);
      // squares beyond the board change nothing
      send_request(OP_PLACE, 1'b0, SQIN_W'(SQUARES), '1, '1, '0);
      send_request(OP_PLACE, 1'b0, '1, '1, '1, '0);
      send_query(OP_COUNT, 1'b0);
      for (int c = OP_CMP + 1; c < (1 << OP_W); c++)
         send_query(OP_W'(c), BANK_W'($urandom));
      send_query(OP_CMP, 1'b0);
      send_request(OP_PLACE, 1'b1, '0, '1, '1, '1);
      send_request(OP_PLACE, 1'b1, SQIN_W'(SQUARES - 1), '0, '0, '1);
      send_query(OP_CMP, 1'b1);
      send_request(OP_PLACE, 1'b1, SQIN_W'(SQUARES - 1), '0, '0, '0);
      send_query(OP_CMP, 1'b0);
      send_query(OP_CLEAR, 1'b0);
      send_query(OP_COUNT, 1'b0);
      send_query(OP_DUP, 1'b0);
      send_query(OP_CLEAR, 1'b1);
      send_query(OP_CMP, 1'b1);
   endtask

   task automatic run_mirror_round(input int n_places, input bit perturb);
      int victim;
      int flip;
      bit skip;
      logic [SQIN_W-1:0] sq;
      logic [COLOR_W-1:0] c;
      logic [KIND_W-1:0] k;
      logic [ID_W-1:0] id;
      victim = (n_places > 0) ? $urandom_range(0, n_places - 1) : 0;
      send_query(OP_CLEAR, 1'b0);
      send_query(OP_CLEAR, 1'b1);
      for (int i = 0; i < n_places; i++) begin
         sq = SQIN_W'($urandom_range(0, SQUARES - 1));
         c = COLOR_W'($urandom);
         k = KIND_W'($urandom);
         id = rand_id();
         skip = 1'b0;
         send_request(OP_PLACE, 1'b0, sq, c, k, id);
         if (perturb && i == victim) begin
            case ($urandom_range(0, 3))
               0: c = ~c;
               1: k = ~k;
               2: begin
                  flip = $urandom_range(0, ID_W - 1);
                  id[flip] = ~id[flip];
               end
               default: skip = 1'b1;
            endcase
         end
         if (!skip) send_request(OP_PLACE, 1'b1, sq, c, k, id);
      end
      send_query(OP_CMP, BANK_W'($urandom));
      send_query(OP_COUNT, 1'b0);
      send_query(OP_COUNT, 1'b1);
      send_query(OP_DUP, 1'b0);
      send_query(OP_DUP, 1'b1);
   endtask

   task automatic test_mirrored_banks();
      run_mirror_round(0, 1'b0);
      run_mirror_round(24, 1'b0);
      run_mirror_round($urandom_range(1, 16), 1'b1);
      run_mirror_round($urandom_range(1, 16), 1'b0);
      run_mirror_round($urandom_range(1, 16), 1'b1);
      run_mirror_round($urandom_range(1, 16), 1'b1);
   endtask

   task automatic run_dup_hunt(input int pool_size, input int n_places);
      logic [BANK_W-1:0] bank;
      logic [ID_W-1:0] id;
      bank = BANK_W'($urandom);
      for (int p = 0; p < pool_size; p++) id_pool[p] = rand_id();
      send_query(OP_CLEAR, bank);
      for (int i = 0; i < n_places; i++) begin
         id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, pool_size - 1)] : rand_id();
         send_request(OP_PLACE, bank, rand_square(), COLOR_W'($urandom), KIND_W'($urandom), id);
         if ($urandom_range(0, 3) == 0) send_query(OP_DUP, bank);
      end
      send_query(OP_DUP, bank);
      send_query(OP_COUNT, bank);
   endtask

   task automatic test_duplicate_hunt();
      run_dup_hunt(1, 6);
      run_dup_hunt(2, 12);
      run_dup_hunt(4, 20);
      run_dup_hunt(8, 24);
      run_dup_hunt(16, 16);
   endtask

   task automatic test_stall_pressure();
      // receiver holds off while the sender keeps offering back to back
      tx_steady = 1'b1;
      hold_requests++;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 0) send_query(OP_DUP, BANK_W'($urandom));
         else if (i % 3 == 1) send_request(OP_PLACE, BANK_W'($urandom), rand_square(),
                                           COLOR_W'($urandom), KIND_W'($urandom), rand_id());
         else send_query(OP_COUNT, BANK_W'($urandom));
      end
      tx_steady = 1'b0;
      wait_all_answered();
      // sender pauses until every result is back, then resumes
      send_query(OP_CMP, BANK_W'($urandom));
      send_query(OP_COUNT, 1'b0);
      wait_all_answered();
      send_query(OP_DUP, 1'b1);
      send_query(OP_COUNT, 1'b1);
   endtask

   task automatic test_random_mix();
      int r;
      logic [OP_W-1:0] op;
      for (int i = 0; i < 110; i++) begin
         // a stretch with no idling on either side
         tx_steady = (i >= 40 && i < 70);
         rx_steady = tx_steady;
         r = $urandom_range(0, 99);
         if (r < 5) op = OP_CLEAR;
         else if (r < 50) op = OP_PLACE;
         else if (r < 65) op = OP_COUNT;
         else if (r < 80) op = OP_DUP;
         else if (r < 95) op = OP_CMP;
         else op = OP_W'($urandom_range(OP_CMP + 1, (1 << OP_W) - 1));
         if (op == OP_PLACE && $urandom_range(0, 1))
            send_request(op, BANK_W'($urandom), rand_square(), COLOR_W'($urandom),
                         KIND_W'($urandom), id_pool[$urandom_range(0, 3)]);
         else
            send_query(op, BANK_W'($urandom));
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_CLEAR;
      req_bank <= '0;
      req_square <= '0;
      req_color <= '0;
      req_piece_kind <= '0;
      req_tag_id <= '0;
      clear_board_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_board_edges();
      test_mirrored_banks();
      test_duplicate_hunt();
      test_stall_pressure();
      test_random_mix();
      wait_all_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d requests, %0d of them queries, over both banks",
               requests_sent, queries_sent);
      $display("%0d results checked, %0d duplicate hits, %0d equal compares",
               answers_checked, dup_hits, equal_hits);
      if (mismatches == 0 && awaited_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
